// ===== sv/aup_pkg.sv =====
// Package for the inverted-alpha unpremultiply block: widths, constants,
// the structs that travel down the pipeline and the divider dividend bits.
// No dependencies.
`default_nettype none

package aup_pkg;

	// Component and datapath widths.
	localparam int unsigned CW     = 16;            // component width
	localparam int unsigned NW     = 8;             // narrow component width
	localparam int unsigned QW     = 49;            // quotient / reciprocal width
	localparam int unsigned RLO_W  = 25;            // low part of the reciprocal
	localparam int unsigned RHI_W  = QW - RLO_W;    // high part of the reciprocal
	localparam int unsigned PLO_W  = CW + RLO_W;    // low partial product width
	localparam int unsigned PHI_W  = CW + RHI_W;    // high partial product width
	localparam int unsigned NCOL   = 3;             // colour channels per pixel

	// Dividend shapes: 65535 << 33 in deep mode, 255 << 16 in narrow mode.
	localparam int unsigned DEEP_NUM_LSB   = 33;
	localparam int unsigned NARROW_NUM_LSB = 16;
	localparam int unsigned NARROW_NUM_MSB = 23;

	// Rounding bit and result position of each mode.
	localparam int unsigned DEEP_RND_BIT   = 32;
	localparam int unsigned NARROW_RND_BIT = 15;
	localparam int unsigned DEEP_SHIFT     = 33;
	localparam int unsigned NARROW_SHIFT   = 16;

	// Pixel context carried alongside the division, colours already masked.
	typedef struct packed {
		logic [CW-1:0] red;
		logic [CW-1:0] green;
		logic [CW-1:0] blue;
		logic [CW-1:0] alpha;
		logic          deep;
		logic          last;
	} aup_ctx_t;

	// One divider stage: context, partial remainder and partial quotient.
	typedef struct packed {
		logic          valid;
		aup_ctx_t      ctx;
		logic [CW-1:0] rem;
		logic [QW-1:0] quo;
	} aup_div_t;

	// Finished straight-alpha pixel.
	typedef struct packed {
		logic [CW-1:0] red;
		logic [CW-1:0] green;
		logic [CW-1:0] blue;
		logic [CW-1:0] alpha;
		logic          last;
	} aup_res_t;

	// Bit of the constant dividend at a given position for the chosen mode.
	function automatic logic num_bit(input logic deep, input int unsigned pos);
		logic b;
		if (deep) begin
			b = (pos >= DEEP_NUM_LSB);
		end else begin
			b = (pos >= NARROW_NUM_LSB) && (pos <= NARROW_NUM_MSB);
		end
		return b;
	endfunction

endpackage

`default_nettype wire

// ===== sv/aup_if.sv =====
// Valid/ready stream interfaces for pixels into and out of the block.
// Depends on aup_pkg for the component width.
`default_nettype none

interface aup_pix_in_if;
	logic                    valid;
	logic                    ready;
	logic [aup_pkg::CW-1:0]  red_in;
	logic [aup_pkg::CW-1:0]  green_in;
	logic [aup_pkg::CW-1:0]  blue_in;
	logic [aup_pkg::CW-1:0]  inv_alpha_in;
	logic                    end_of_image;

	modport source (output valid, red_in, green_in, blue_in, inv_alpha_in, end_of_image,
	                input ready);
	modport sink   (input valid, red_in, green_in, blue_in, inv_alpha_in, end_of_image,
	                output ready);
endinterface

interface aup_pix_out_if;
	logic                    valid;
	logic                    ready;
	logic [aup_pkg::CW-1:0]  red_out;
	logic [aup_pkg::CW-1:0]  green_out;
	logic [aup_pkg::CW-1:0]  blue_out;
	logic [aup_pkg::CW-1:0]  alpha_out;
	logic                    last_out;

	modport source (output valid, red_out, green_out, blue_out, alpha_out, last_out,
	                input ready);
	modport sink   (input valid, red_out, green_out, blue_out, alpha_out, last_out,
	                output ready);
endinterface

`default_nettype wire

// ===== sv/alpha_unpremultiply_inverted_top.sv =====
// Top level of the inverted-alpha unpremultiply block.
// Depends on aup_pkg, aup_if, aup_div_stage, aup_scale and aup_skid.
//
// Takes one premultiplied pixel with inverted alpha per beat and returns the
// straight-alpha pixel, one pixel per clock while the output does not stall.
// The path runs through one input stage, 49 stages of the restoring divider
// that forms the reciprocal (one quotient bit per stage, set by the 49-bit
// reciprocal of deep mode), three scaling stages and the output register.
// deep_mode selects 16-bit components when set and
// 8-bit components otherwise; write it only while no pixel is in flight.
// A zero alpha passes the masked colours through unchanged.
`default_nettype none

module alpha_unpremultiply_inverted_top (
	input  wire           clk,
	input  wire           arst_n,
	input  wire           cfg_we,
	input  wire           cfg_wdata,
	aup_pix_in_if.sink    pix_in,
	aup_pix_out_if.source pix_out
);
	import aup_pkg::*;

	logic     deep_mode_q;
	logic     ce;
	logic     front_valid_s1;
	aup_ctx_t front_ctx_s1;
	aup_div_t div_chain [QW+1];
	logic     res_valid;
	aup_res_t res;

	// Configuration register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			deep_mode_q <= 1'b0;
		end else if (cfg_we) begin
			deep_mode_q <= cfg_wdata;
		end
	end

	assign pix_in.ready = ce;

	// Input stage: mask to the component width and restore the alpha.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			front_valid_s1 <= 1'b0;
		end else if (ce) begin
			front_valid_s1 <= pix_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ce) begin
			front_ctx_s1.deep <= deep_mode_q;
			front_ctx_s1.last <= pix_in.end_of_image;
			if (deep_mode_q) begin
				front_ctx_s1.red   <= pix_in.red_in;
				front_ctx_s1.green <= pix_in.green_in;
				front_ctx_s1.blue  <= pix_in.blue_in;
				front_ctx_s1.alpha <= ~pix_in.inv_alpha_in;
			end else begin
				front_ctx_s1.red   <= {{(CW-NW){1'b0}}, pix_in.red_in[NW-1:0]};
				front_ctx_s1.green <= {{(CW-NW){1'b0}}, pix_in.green_in[NW-1:0]};
				front_ctx_s1.blue  <= {{(CW-NW){1'b0}}, pix_in.blue_in[NW-1:0]};
				front_ctx_s1.alpha <= {{(CW-NW){1'b0}}, ~pix_in.inv_alpha_in[NW-1:0]};
			end
		end
	end

	// Divider: one stage per quotient bit, most significant first. The
	// remainder and quotient start at zero.
	assign div_chain[0] = '{valid: front_valid_s1, ctx: front_ctx_s1, rem: '0, quo: '0};

	for (genvar k = 0; k < QW; k++) begin : g_div
		aup_div_stage #(
			.POS(QW - 1 - k)
		) u_stage (
			.clk    (clk),
			.arst_n (arst_n),
			.ce     (ce),
			.d      (div_chain[k]),
			.q      (div_chain[k+1])
		);
	end

	// Reciprocal, multiply and round.
	aup_scale u_scale (
		.clk       (clk),
		.arst_n    (arst_n),
		.ce        (ce),
		.d         (div_chain[QW]),
		.res_valid (res_valid),
		.res       (res)
	);

	// Output register and skid entry.
	aup_skid u_skid (
		.clk       (clk),
		.arst_n    (arst_n),
		.res_valid (res_valid),
		.res       (res),
		.ce        (ce),
		.pix_out   (pix_out)
	);

endmodule

`default_nettype wire

// ===== sv/aup_div_stage.sv =====
// One step of the pipelined restoring divider: brings down one dividend bit,
// compares with alpha and subtracts. Depends on aup_pkg.
`default_nettype none

module aup_div_stage #(
	parameter int unsigned POS = 0
) (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               ce,
	input  aup_pkg::aup_div_t d,
	output aup_pkg::aup_div_t q
);
	import aup_pkg::*;

	logic [CW:0]   trial;
	logic          fits;
	logic [CW-1:0] rem_nxt;
	logic          valid_s1;
	aup_ctx_t      ctx_s1;
	logic [CW-1:0] rem_s1;
	logic [QW-1:0] quo_s1;

	// Shift the next dividend bit into the remainder and try the subtraction.
	always_comb begin
		trial   = {d.rem, num_bit(d.ctx.deep, POS)};
		fits    = (trial >= {1'b0, d.ctx.alpha});
		rem_nxt = fits ? CW'(trial - {1'b0, d.ctx.alpha}) : trial[CW-1:0];
	end

	// Valid bit is control and is reset; the rest is payload.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (ce) begin
			valid_s1 <= d.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ce) begin
			ctx_s1 <= d.ctx;
			rem_s1 <= rem_nxt;
			quo_s1 <= {d.quo[QW-2:0], fits};
		end
	end

	always_comb begin
		q.valid = valid_s1;
		q.ctx   = ctx_s1;
		q.rem   = rem_s1;
		q.quo   = quo_s1;
	end

endmodule

`default_nettype wire

// ===== sv/aup_scale.sv =====
// Scaling back end: forms the reciprocal, multiplies each colour by it in
// two partial products and rounds to the component width. Depends on aup_pkg.
`default_nettype none

module aup_scale (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               ce,
	input  aup_pkg::aup_div_t d,
	output logic              res_valid,
	output aup_pkg::aup_res_t res
);
	import aup_pkg::*;

	logic          valid_s1, valid_s2, valid_s3;
	aup_ctx_t      ctx_s1, ctx_s2;
	logic          zero_s1, zero_s2;
	logic [QW-1:0] recip_s1;
	logic [PLO_W-1:0] plo_s2 [NCOL];
	logic [PHI_W-1:0] phi_s2 [NCOL];
	aup_res_t      res_s3;

	logic [CW-1:0] col_s1 [NCOL];
	logic [CW-1:0] col_s2 [NCOL];
	logic [QW-1:0] rnd_s2;
	logic [QW-1:0] tot    [NCOL];
	logic [CW-1:0] scaled [NCOL];

	// Valid bits of the three stages.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else if (ce) begin
			valid_s1 <= d.valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	// Stage 1: reciprocal is the quotient plus one; note a zero alpha.
	always_ff @(posedge clk) begin
		if (ce) begin
			ctx_s1   <= d.ctx;
			recip_s1 <= d.quo + QW'(1);
			zero_s1  <= (d.ctx.alpha == '0);
		end
	end

	always_comb begin
		col_s1[0] = ctx_s1.red;
		col_s1[1] = ctx_s1.green;
		col_s1[2] = ctx_s1.blue;
		col_s2[0] = ctx_s2.red;
		col_s2[1] = ctx_s2.green;
		col_s2[2] = ctx_s2.blue;
	end

	// Stage 2: two partial products per colour, low and high reciprocal halves.
	always_ff @(posedge clk) begin
		if (ce) begin
			ctx_s2  <= ctx_s1;
			zero_s2 <= zero_s1;
			for (int i = 0; i < NCOL; i++) begin
				plo_s2[i] <= {{RLO_W{1'b0}}, col_s1[i]} *
				             {{CW{1'b0}}, recip_s1[RLO_W-1:0]};
				phi_s2[i] <= {{RHI_W{1'b0}}, col_s1[i]} *
				             {{CW{1'b0}}, recip_s1[QW-1:RLO_W]};
			end
		end
	end

	// Stage 3: join the partial products, add the rounding bit and pick the kept bits,
	// or keep the colours for a zero alpha. Only the low QW bits matter, so the sum wraps harmlessly.
	always_comb begin
		rnd_s2 = ctx_s2.deep ? (QW'(1) << DEEP_RND_BIT) : (QW'(1) << NARROW_RND_BIT);
		for (int i = 0; i < NCOL; i++) begin
			tot[i] = QW'(plo_s2[i]) + {phi_s2[i][RHI_W-1:0], {RLO_W{1'b0}}} + rnd_s2;
			if (zero_s2) begin
				scaled[i] = col_s2[i];
			end else if (ctx_s2.deep) begin
				scaled[i] = tot[i][DEEP_SHIFT +: CW];
			end else begin
				scaled[i] = {{(CW-NW){1'b0}}, tot[i][NARROW_SHIFT +: NW]};
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ce) begin
			res_s3.red   <= scaled[0];
			res_s3.green <= scaled[1];
			res_s3.blue  <= scaled[2];
			res_s3.alpha <= ctx_s2.alpha;
			res_s3.last  <= ctx_s2.last;
		end
	end

	assign res_valid = valid_s3;
	assign res       = res_s3;

endmodule

`default_nettype wire

// ===== sv/aup_skid.sv =====
// Output register with a skid entry. The pipeline advances only while the
// skid entry is empty, so the stall never reaches the input combinationally.
// Depends on aup_pkg and aup_if.
`default_nettype none

module aup_skid (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               res_valid,
	input  aup_pkg::aup_res_t res,
	output logic              ce,
	aup_pix_out_if.source     pix_out
);
	import aup_pkg::*;

	logic     out_valid_q, skid_valid_q;
	aup_res_t out_q, skid_q;
	logic     push, take, out_free;

	// A beat leaves the pipeline only on a cycle the pipeline advances.
	assign ce       = !skid_valid_q;
	assign push     = res_valid && ce;
	assign take     = out_valid_q && pix_out.ready;
	assign out_free = !out_valid_q || take;

	// Occupancy of the output and skid entries.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q  <= skid_valid_q || push;
			skid_valid_q <= 1'b0;
		end else if (push) begin
			skid_valid_q <= 1'b1;
		end
	end

	// Payload moves with the occupancy above.
	always_ff @(posedge clk) begin
		if (out_free) begin
			out_q <= skid_valid_q ? skid_q : res;
		end else if (push) begin
			skid_q <= res;
		end
	end

	assign pix_out.valid     = out_valid_q;
	assign pix_out.red_out   = out_q.red;
	assign pix_out.green_out = out_q.green;
	assign pix_out.blue_out  = out_q.blue;
	assign pix_out.alpha_out = out_q.alpha;
	assign pix_out.last_out  = out_q.last;

endmodule

`default_nettype wire

// ===== sv/aup_checker.sv =====
// Port-level checks of the inverted-alpha unpremultiply block, and the bind
// that attaches them to the top level. Depends on aup_pkg and the top level.
`default_nettype none

module aup_checker (
	input wire                   clk,
	input wire                   arst_n,
	input wire                   in_ready,
	input wire                   out_valid,
	input wire                   out_ready,
	input wire [aup_pkg::CW-1:0] red_out,
	input wire [aup_pkg::CW-1:0] alpha_out,
	input wire                   last_out
);

	// A result beat that is offered stays offered until it is taken.
	a_out_valid_holds: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result beat withdrawn before it was taken");

	// A stalled result beat keeps its payload.
	a_out_payload_holds: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(red_out) && $stable(alpha_out) && $stable(last_out))
		else $error("stalled result beat changed its payload");

	// The input is only held off while a finished result waits at the output.
	a_stall_needs_result: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid)
		else $error("input stalled with no result waiting");

	// Once stalled, the input stays stalled until a result beat is taken.
	a_stall_until_take: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready && !(out_valid && out_ready) |=> !in_ready)
		else $error("input stall released without a result beat leaving");

endmodule

bind alpha_unpremultiply_inverted_top aup_checker u_aup_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_ready  (pix_in.ready),
	.out_valid (pix_out.valid),
	.out_ready (pix_out.ready),
	.red_out   (pix_out.red_out),
	.alpha_out (pix_out.alpha_out),
	.last_out  (pix_out.last_out)
);

`default_nettype wire

// ===== tb/alpha_unpremultiply_inverted_top_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for alpha_unpremultiply_inverted_top: it streams pixels through
// the valid/ready interfaces, predicts every straight-alpha pixel and checks each result.
// Depends on aup_pkg, aup_if.sv and the block itself.

module alpha_unpremultiply_inverted_top_tb;
	import aup_pkg::*;

	localparam int unsigned PIPE_LATENCY = 54;
	localparam int unsigned QUIET_LIMIT  = 5000;
	localparam int unsigned LONG_HOLD    = 400;
	localparam int unsigned PHASE_PIXELS = 140;

	logic clk       = 1'b0;
	logic arst_n    = 1'b0;
	logic cfg_we    = 1'b0;
	logic cfg_wdata = 1'b0;

	aup_pix_in_if  pix_in_bus ();
	aup_pix_out_if pix_out_bus ();

	alpha_unpremultiply_inverted_top dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.pix_in   (pix_in_bus),
		.pix_out  (pix_out_bus)
	);

	// Mirror of the depth register and the pixels still owed by the block.
	logic        depth_is_deep = 1'b0;
	aup_res_t    straight_pixels [$];
	int unsigned send_idle_pct   = 0;
	int unsigned recv_stall_pct  = 0;
	int unsigned hold_request    = 0;
	int unsigned mismatch_count  = 0;
	int unsigned pixels_sent     = 0;
	int unsigned pixels_checked  = 0;
	int unsigned depth_writes    = 0;
	int unsigned quiet_cycles    = 0;

	// Free-running clock, 20 ns period.
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Straight-alpha pixel for one premultiplied pixel with inverted alpha.
	function automatic aup_res_t unpremultiply(input logic [CW-1:0] r, g, b, inv_a,
			input logic eoi, input logic deep);
		logic [63:0] mask;
		logic [63:0] dividend;
		logic [63:0] round_bit;
		logic [63:0] alpha;
		logic [63:0] recip;
		logic [63:0] chan [NCOL];
		int unsigned shift;
		aup_res_t    res;
		mask      = deep ? 64'hFFFF : 64'hFF;
		dividend  = deep ? (64'd65535 << 33) : (64'd255 << 16);
		round_bit = deep ? (64'd1 << 32) : (64'd1 << 15);
		shift     = deep ? 33 : 16;
		chan[0]   = {48'd0, r} & mask;
		chan[1]   = {48'd0, g} & mask;
		chan[2]   = {48'd0, b} & mask;
		alpha     = ~{48'd0, inv_a} & mask;
		if (alpha != 64'd0) begin
			recip = dividend / alpha + 64'd1;
			// The product wraps at 64 bits; the kept bits are never touched by it.
			for (int i = 0; i < NCOL; i++) begin
				chan[i] = ((chan[i] * recip + round_bit) >> shift) & mask;
			end
		end
		res.red   = chan[0][CW-1:0];
		res.green = chan[1][CW-1:0];
		res.blue  = chan[2][CW-1:0];
		res.alpha = alpha[CW-1:0];
		res.last  = eoi;
		return res;
	endfunction

	task automatic report_mismatch(input string what, input logic [CW-1:0] got,
			input logic [CW-1:0] want);
		$display("[%0t] result %0d: %s got %h, expected %h", $time, pixels_checked, what,
			got, want);
		mismatch_count++;
	endtask

	// Offer one pixel after a random gap and hold it until the beat is taken.
	task automatic send_pixel(input logic [CW-1:0] r, g, b, inv_a, input logic eoi);
		int unsigned gap;
		gap = 0;
		while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct && gap < 40) begin
			gap++;
		end
		@(negedge clk);
		if (gap != 0) begin
			pix_in_bus.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		pix_in_bus.valid        <= 1'b1;
		pix_in_bus.red_in       <= r;
		pix_in_bus.green_in     <= g;
		pix_in_bus.blue_in      <= b;
		pix_in_bus.inv_alpha_in <= inv_a;
		pix_in_bus.end_of_image <= eoi;
		do @(posedge clk); while (!pix_in_bus.ready);
		straight_pixels.push_back(unpremultiply(r, g, b, inv_a, eoi, depth_is_deep));
		pixels_sent++;
	endtask

	// Random pixel: mostly well-formed premultiplied colours, some oversized ones.
	task automatic send_random_pixel();
		logic [CW-1:0] mask;
		logic [CW-1:0] alpha;
		logic [CW-1:0] inv_a;
		logic [CW-1:0] col [NCOL];
		mask = depth_is_deep ? 16'hFFFF : 16'h00FF;
		case ($urandom_range(9))
			0: begin
				alpha = '0;
			end
			1: begin
				alpha = mask;
			end
			2: begin
				alpha = CW'($urandom_range(4, 1));
			end
			default: begin
				alpha = CW'($urandom) & mask;
			end
		endcase
		for (int i = 0; i < NCOL; i++) begin
			if ($urandom_range(9) < 7) begin
				col[i] = CW'($urandom_range(alpha));
			end else begin
				col[i] = CW'($urandom) & mask;
			end
			// The upper byte is ignored at 8-bit depth, so fill it with noise.
			col[i] = col[i] | (CW'($urandom) & ~mask);
		end
		inv_a = (~alpha & mask) | (CW'($urandom) & ~mask);
		send_pixel(col[0], col[1], col[2], inv_a, $urandom_range(15) == 0);
	endtask

	task automatic idle_input();
		@(negedge clk);
		pix_in_bus.valid <= 1'b0;
	endtask

	// Stop offering and wait until every owed pixel has come back.
	task automatic drain();
		idle_input();
		while (straight_pixels.size() != 0) @(posedge clk);
	endtask

	task automatic write_depth(input logic deep);
		drain();
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= deep;
		@(posedge clk);
		depth_is_deep = deep;
		depth_writes++;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// 8-bit depth straight after reset: zero alpha, full alpha, tiny alpha and junk upper bytes.
	task automatic test_narrow_corners();
		send_pixel(16'h0000, 16'h0000, 16'h0000, 16'h00FF, 1'b0);
		send_pixel(16'h00FF, 16'h0080, 16'h0001, 16'h00FF, 1'b1);
		send_pixel(16'h00FF, 16'h00FF, 16'h00FF, 16'h0000, 1'b0);
		send_pixel(16'h0000, 16'h007F, 16'h0080, 16'h0000, 1'b0);
		send_pixel(16'h0001, 16'h0000, 16'h00FF, 16'h00FE, 1'b0);
		send_pixel(16'h0040, 16'h0080, 16'h00C0, 16'h007F, 1'b1);
		send_pixel(16'hAB12, 16'hFF34, 16'h0156, 16'hFF80, 1'b0);
		send_pixel(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hA5FF, 1'b0);
		send_pixel(16'h0010, 16'h0020, 16'h0030, 16'h00CF, 1'b1);
	endtask

	// 16-bit depth: zero and full alpha, alpha of one with a wrapping product.
	task automatic test_deep_corners();
		write_depth(1'b1);
		send_pixel(16'hFFFF, 16'h1234, 16'h0000, 16'hFFFF, 1'b1);
		send_pixel(16'hFFFF, 16'h8000, 16'h0000, 16'h0000, 1'b0);
		send_pixel(16'h0001, 16'h0000, 16'hFFFF, 16'hFFFE, 1'b0);
		send_pixel(16'h4000, 16'h8000, 16'hFFFF, 16'h7FFF, 1'b0);
		send_pixel(16'h00FF, 16'h0080, 16'h0001, 16'hFF00, 1'b1);
		send_pixel(16'hFFFE, 16'hFFFF, 16'h0001, 16'h0001, 1'b0);
	endtask

	// Random streams at both depths under each idling pattern.
	task automatic test_random_phases();
		int unsigned send_pct [4];
		int unsigned recv_pct [4];
		send_pct = '{0, 68, 0, 17};
		recv_pct = '{0, 0, 68, 17};
		for (int p = 0; p < 4; p++) begin
			for (int d = 0; d < 2; d++) begin
				write_depth(d[0]);
				send_idle_pct  = send_pct[p];
				recv_stall_pct = recv_pct[p];
				repeat (PHASE_PIXELS) send_random_pixel();
			end
		end
	endtask

	// Long receiver hold-off while pixels keep coming, a full drain, then random stalls.
	task automatic test_fill_and_stall();
		write_depth(1'b0);
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		hold_request   = LONG_HOLD;
		repeat (150) send_random_pixel();
		drain();
		recv_stall_pct = 17;
		repeat (20) send_random_pixel();
	endtask

	// Stimulus sequence and final verdict.
	initial begin
		pix_in_bus.valid        = 1'b0;
		pix_in_bus.red_in       = '0;
		pix_in_bus.green_in     = '0;
		pix_in_bus.blue_in      = '0;
		pix_in_bus.inv_alpha_in = '0;
		pix_in_bus.end_of_image = 1'b0;
		repeat (2) @(negedge clk);
		arst_n = 1'b1;

		test_narrow_corners();
		test_deep_corners();
		test_random_phases();
		test_fill_and_stall();

		drain();
		repeat (PIPE_LATENCY + 10) @(posedge clk);
		if (straight_pixels.size() != 0) begin
			report_mismatch("pixels never returned", '0, CW'(straight_pixels.size()));
		end
		$display("Run covered %0d pixels at both depths, %0d depth writes, under four idling patterns",
			pixels_sent, depth_writes);
		$display("and a long receiver hold-off; %0d results compared, %0d mismatches.",
			pixels_checked, mismatch_count);
		if (mismatch_count == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

	// Receiver: random stalls, plus a long hold-off counted down here when asked for.
	initial begin
		int unsigned hold_left;
		hold_left = 0;
		pix_out_bus.ready = 1'b0;
		wait (arst_n);
		forever begin
			@(negedge clk);
			if (hold_request != 0) begin
				hold_left    = hold_request;
				hold_request = 0;
			end
			if (hold_left != 0) begin
				pix_out_bus.ready <= 1'b0;
				hold_left--;
			end else begin
				pix_out_bus.ready <= ($urandom_range(99) >= recv_stall_pct);
			end
		end
	end

	// Compare every output beat with the oldest owed pixel.
	always @(posedge clk) begin
		aup_res_t want;
		if (arst_n && pix_out_bus.valid && pix_out_bus.ready) begin
			if (straight_pixels.size() == 0) begin
				report_mismatch("beat with nothing owed, red_out", pix_out_bus.red_out, '0);
			end else begin
				want = straight_pixels.pop_front();
				if (pix_out_bus.red_out !== want.red)
					report_mismatch("red_out", pix_out_bus.red_out, want.red);
				if (pix_out_bus.green_out !== want.green)
					report_mismatch("green_out", pix_out_bus.green_out, want.green);
				if (pix_out_bus.blue_out !== want.blue)
					report_mismatch("blue_out", pix_out_bus.blue_out, want.blue);
				if (pix_out_bus.alpha_out !== want.alpha)
					report_mismatch("alpha_out", pix_out_bus.alpha_out, want.alpha);
				if (pix_out_bus.last_out !== want.last)
					report_mismatch("last_out", {{(CW-1){1'b0}}, pix_out_bus.last_out},
						{{(CW-1){1'b0}}, want.last});
				pixels_checked++;
			end
		end
	end

	// Watchdog: give up when no beat moves on either side for too long.
	always @(posedge clk) begin
		if ((pix_in_bus.valid && pix_in_bus.ready) || (pix_out_bus.valid && pix_out_bus.ready)) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("[%0t] watchdog: no beat for %0d cycles, %0d pixels owed", $time,
					quiet_cycles, straight_pixels.size());
				$display("CHECKS FAILED");
				$finish;
			end
		end
	end

endmodule
